>>> hdl/cna_pkg.sv
// ----------------------------------------------------------------------------
// Complex ALU package
// Shared widths, transaction types and the saturation function.
// ----------------------------------------------------------------------------
package cna_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_W      = 2 * DATA_WIDTH;
    localparam int SUM_W       = PROD_W + 1;
    localparam int DEN_W       = PROD_W;
    localparam int MAG_W       = PROD_W + FRAC_BITS;
    localparam int QB          = DATA_WIDTH + 1;
    localparam int CMP_W       = DEN_W + QB;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [SUM_W-1:0] SAT_HI =
        (SUM_W'(1) <<< (DATA_WIDTH - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) <<< (DATA_WIDTH - 1));

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]                   mode;
        logic signed [DATA_WIDTH-1:0] a_real;
        logic signed [DATA_WIDTH-1:0] a_imag;
        logic signed [DATA_WIDTH-1:0] b_real;
        logic signed [DATA_WIDTH-1:0] b_imag;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] res_real;
        logic signed [DATA_WIDTH-1:0] res_imag;
        logic                         overflow;
        logic                         div_by_zero;
    } t_out_item;

    typedef struct packed {
        t_mode                        op;
        logic                         b_zero;
        logic signed [DATA_WIDTH-1:0] ar;
        logic signed [DATA_WIDTH-1:0] ai;
        logic signed [DATA_WIDTH-1:0] br;
        logic signed [DATA_WIDTH-1:0] bi;
    } t_cmd;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] val;
        logic                         ovf;
    } t_sat;

    function automatic t_sat sat_word(input logic signed [SUM_W-1:0] v);
        t_sat r;
        r.ovf = 1'b0;
        r.val = v[DATA_WIDTH-1:0];
        if (v > SAT_HI) begin
            r.ovf = 1'b1;
            r.val = SAT_HI[DATA_WIDTH-1:0];
        end else if (v < SAT_LO) begin
            r.ovf = 1'b1;
            r.val = SAT_LO[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/cna_front.sv
// ----------------------------------------------------------------------------
// Complex ALU front end
// Registers each accepted transaction and classifies its operation.
// ----------------------------------------------------------------------------
module cna_front import cna_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    always_comb begin
        n_cmd.op     = t_mode'(i_item.mode);
        n_cmd.b_zero = (i_item.b_real == '0) && (i_item.b_imag == '0);
        n_cmd.ar     = i_item.a_real;
        n_cmd.ai     = i_item.a_imag;
        n_cmd.br     = i_item.b_real;
        n_cmd.bi     = i_item.b_imag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_push = r_valid;
    assign o_cmd  = r_cmd;

endmodule

>>> hdl/cna_queue.sv
// ----------------------------------------------------------------------------
// Complex ALU command queue
// Small FIFO that decouples the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module cna_queue import cna_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_ctl  i_ctl,
    input  t_cmd    i_cmd,
    output t_q_stat o_stat,
    output logic    o_valid,
    output t_cmd    o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              r_valid;
    t_cmd              r_cmd;
    logic              w_push;
    logic              w_pop;

    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push       = i_ctl.push && !o_stat.full;
    assign w_pop        = i_ctl.pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= w_pop;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
        if (w_pop) begin
            r_cmd <= r_mem[r_rd_ptr];
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

>>> hdl/cna_back.sv
// ----------------------------------------------------------------------------
// Complex ALU back end
// Product stage, combine stage, pipelined restoring divider and saturation.
// ----------------------------------------------------------------------------
module cna_back import cna_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cmd      i_cmd,
    output logic      o_valid,
    output t_out_item o_result
);

    typedef struct packed {
        t_mode                        op;
        logic                         b_zero;
        logic signed [DATA_WIDTH-1:0] ar;
        logic signed [DATA_WIDTH-1:0] ai;
        logic signed [DATA_WIDTH-1:0] br;
        logic signed [DATA_WIDTH-1:0] bi;
        logic signed [PROD_W-1:0]     p0;
        logic signed [PROD_W-1:0]     p1;
        logic signed [PROD_W-1:0]     p2;
        logic signed [PROD_W-1:0]     p3;
        logic signed [PROD_W-1:0]     p4;
        logic signed [PROD_W-1:0]     p5;
    } t_prod;

    typedef struct packed {
        logic                    is_div;
        logic                    b_zero;
        logic signed [SUM_W-1:0] direct_r;
        logic signed [SUM_W-1:0] direct_i;
        logic                    sign_r;
        logic                    sign_i;
    } t_side;

    typedef struct packed {
        t_side            side;
        logic [MAG_W-1:0] num_r;
        logic [MAG_W-1:0] num_i;
        logic [DEN_W-1:0] den;
    } t_comb;

    typedef struct packed {
        t_side            side;
        logic             big_r;
        logic             big_i;
        logic [MAG_W-1:0] rem_r;
        logic [MAG_W-1:0] rem_i;
        logic [DEN_W-1:0] den;
        logic [QB-1:0]    q_r;
        logic [QB-1:0]    q_i;
    } t_dstage;

    logic    r_s1_valid;
    t_prod   r_s1;
    t_prod   n_s1;
    logic    r_s2_valid;
    t_comb   r_s2;
    t_comb   n_s2;
    logic    r_dv_valid [QB+1];
    t_dstage r_dv       [QB+1];
    t_dstage n_dv       [QB+1];
    logic    r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    always_comb begin
        n_s1.op     = i_cmd.op;
        n_s1.b_zero = i_cmd.b_zero;
        n_s1.ar     = i_cmd.ar;
        n_s1.ai     = i_cmd.ai;
        n_s1.br     = i_cmd.br;
        n_s1.bi     = i_cmd.bi;
        n_s1.p0     = PROD_W'(i_cmd.ar) * PROD_W'(i_cmd.br);
        n_s1.p1     = PROD_W'(i_cmd.ai) * PROD_W'(i_cmd.bi);
        n_s1.p2     = PROD_W'(i_cmd.ar) * PROD_W'(i_cmd.bi);
        n_s1.p3     = PROD_W'(i_cmd.br) * PROD_W'(i_cmd.ai);
        n_s1.p4     = PROD_W'(i_cmd.br) * PROD_W'(i_cmd.br);
        n_s1.p5     = PROD_W'(i_cmd.bi) * PROD_W'(i_cmd.bi);
    end

    logic signed [SUM_W-1:0] w_num_r;
    logic signed [SUM_W-1:0] w_num_i;
    logic signed [SUM_W-1:0] w_neg_r;
    logic signed [SUM_W-1:0] w_neg_i;
    logic signed [SUM_W-1:0] w_mul_r;
    logic signed [SUM_W-1:0] w_mul_i;

    always_comb begin
        w_mul_r = SUM_W'(r_s1.p0) - SUM_W'(r_s1.p1);
        w_mul_i = SUM_W'(r_s1.p2) + SUM_W'(r_s1.p3);
        w_num_r = SUM_W'(r_s1.p0) + SUM_W'(r_s1.p1);
        w_num_i = SUM_W'(r_s1.p3) - SUM_W'(r_s1.p2);
        w_neg_r = -w_num_r;
        w_neg_i = -w_num_i;
        n_s2.side.is_div = (r_s1.op == MODE_DIV);
        n_s2.side.b_zero = r_s1.b_zero;
        n_s2.side.sign_r = w_num_r[SUM_W-1];
        n_s2.side.sign_i = w_num_i[SUM_W-1];
        case (r_s1.op)
            MODE_ADD: begin
                n_s2.side.direct_r = SUM_W'(r_s1.ar) + SUM_W'(r_s1.br);
                n_s2.side.direct_i = SUM_W'(r_s1.ai) + SUM_W'(r_s1.bi);
            end
            MODE_SUB: begin
                n_s2.side.direct_r = SUM_W'(r_s1.ar) - SUM_W'(r_s1.br);
                n_s2.side.direct_i = SUM_W'(r_s1.ai) - SUM_W'(r_s1.bi);
            end
            MODE_MUL: begin
                n_s2.side.direct_r = w_mul_r >>> FRAC_BITS;
                n_s2.side.direct_i = w_mul_i >>> FRAC_BITS;
            end
            default: begin
                n_s2.side.direct_r = '0;
                n_s2.side.direct_i = '0;
            end
        endcase
        n_s2.num_r = MAG_W'(w_num_r[SUM_W-1] ? w_neg_r[PROD_W-1:0] : w_num_r[PROD_W-1:0])
                     << FRAC_BITS;
        n_s2.num_i = MAG_W'(w_num_i[SUM_W-1] ? w_neg_i[PROD_W-1:0] : w_num_i[PROD_W-1:0])
                     << FRAC_BITS;
        n_s2.den   = DEN_W'(r_s1.p4) + DEN_W'(r_s1.p5);
    end

    logic [CMP_W-1:0] w_lim;
    logic [CMP_W-1:0] w_trial [QB];

    always_comb begin
        w_lim = CMP_W'(r_s2.den) << QB;
        n_dv[0].side  = r_s2.side;
        n_dv[0].big_r = (CMP_W'(r_s2.num_r) >= w_lim);
        n_dv[0].big_i = (CMP_W'(r_s2.num_i) >= w_lim);
        n_dv[0].rem_r = r_s2.num_r;
        n_dv[0].rem_i = r_s2.num_i;
        n_dv[0].den   = r_s2.den;
        n_dv[0].q_r   = '0;
        n_dv[0].q_i   = '0;
        for (int k = 0; k < QB; k++) begin
            w_trial[k]  = CMP_W'(r_dv[k].den) << (QB - 1 - k);
            n_dv[k+1]   = r_dv[k];
            if (CMP_W'(r_dv[k].rem_r) >= w_trial[k]) begin
                n_dv[k+1].rem_r            = r_dv[k].rem_r - w_trial[k][MAG_W-1:0];
                n_dv[k+1].q_r[QB - 1 - k]  = 1'b1;
            end
            if (CMP_W'(r_dv[k].rem_i) >= w_trial[k]) begin
                n_dv[k+1].rem_i            = r_dv[k].rem_i - w_trial[k][MAG_W-1:0];
                n_dv[k+1].q_i[QB - 1 - k]  = 1'b1;
            end
        end
    end

    t_sat                    w_sat_r;
    t_sat                    w_sat_i;
    logic signed [SUM_W-1:0] w_qs_r;
    logic signed [SUM_W-1:0] w_qs_i;

    always_comb begin
        w_qs_r = $signed(SUM_W'(r_dv[QB].q_r));
        w_qs_i = $signed(SUM_W'(r_dv[QB].q_i));
        if (r_dv[QB].side.sign_r) begin
            w_qs_r = -w_qs_r;
        end
        if (r_dv[QB].side.sign_i) begin
            w_qs_i = -w_qs_i;
        end
        if (!r_dv[QB].side.is_div) begin
            w_sat_r = sat_word(r_dv[QB].side.direct_r);
            w_sat_i = sat_word(r_dv[QB].side.direct_i);
        end else begin
            w_sat_r = sat_word(w_qs_r);
            w_sat_i = sat_word(w_qs_i);
            if (r_dv[QB].big_r) begin
                w_sat_r.ovf = 1'b1;
                w_sat_r.val = r_dv[QB].side.sign_r ? SAT_LO[DATA_WIDTH-1:0]
                                                   : SAT_HI[DATA_WIDTH-1:0];
            end
            if (r_dv[QB].big_i) begin
                w_sat_i.ovf = 1'b1;
                w_sat_i.val = r_dv[QB].side.sign_i ? SAT_LO[DATA_WIDTH-1:0]
                                                   : SAT_HI[DATA_WIDTH-1:0];
            end
        end
        if (r_dv[QB].side.is_div && r_dv[QB].side.b_zero) begin
            n_out.res_real    = '0;
            n_out.res_imag    = '0;
            n_out.overflow    = 1'b0;
            n_out.div_by_zero = 1'b1;
        end else begin
            n_out.res_real    = w_sat_r.val;
            n_out.res_imag    = w_sat_i.val;
            n_out.overflow    = w_sat_r.ovf | w_sat_i.ovf;
            n_out.div_by_zero = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k <= QB; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
        end else begin
            r_s1_valid    <= i_valid;
            r_s2_valid    <= r_s1_valid;
            r_dv_valid[0] <= r_s2_valid;
            for (int k = 0; k < QB; k++) begin
                r_dv_valid[k+1] <= r_dv_valid[k];
            end
            r_out_valid <= r_dv_valid[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_s2  <= n_s2;
        r_out <= n_out;
        for (int k = 0; k <= QB; k++) begin
            r_dv[k] <= n_dv[k];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

>>> hdl/complex_number_alu_core.sv
// ----------------------------------------------------------------------------
// Complex number ALU
// Add, subtract, multiply and divide on complex Q16.16 operands.
// ----------------------------------------------------------------------------
// A transaction is accepted at a rising edge where start is high and busy is
// low; i_item carries the mode and the operands a and b.
// Each transaction yields one result on o_result, marked by o_valid for
// exactly one cycle.
// One transaction can be accepted every cycle while busy is low; results leave in order.
// The latency is set by the 33-stage restoring divider, one quotient bit per
// stage, which every transaction passes through so that all modes share the
// same latency.
// The front end registers and classifies the transaction, a four-entry queue
// hands it to the back end, and the back end forms products, sums, quotients
// and saturates.
// The receiver cannot stall, so busy only rises if the queue fills.
// Reset clears all valid bits; no result is produced for transactions that
// were in flight at reset.
// ----------------------------------------------------------------------------
module complex_number_alu_core import cna_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_out_item o_result
);

    logic    w_accept;
    logic    w_push;
    t_cmd    w_front_cmd;
    t_q_ctl  w_qctl;
    t_q_stat w_qstat;
    logic    w_q_valid;
    t_cmd    w_q_cmd;

    assign busy     = w_qstat.full;
    assign w_accept = start && !busy;

    cna_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_item),
        .o_push   (w_push),
        .o_cmd    (w_front_cmd)
    );

    assign w_qctl.push = w_push;
    assign w_qctl.pop  = !w_qstat.empty;

    cna_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_qctl),
        .i_cmd   (w_front_cmd),
        .o_stat  (w_qstat),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    cna_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_cmd    (w_q_cmd),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

>>> hdl/cna_checker.sv
// ----------------------------------------------------------------------------
// Complex ALU port checker
// Concurrent assertions on the top-level ports, bound to the core.
// ----------------------------------------------------------------------------
module cna_checker import cna_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_valid,
    input t_out_item o_result
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised although the back end never stalls");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##40 o_valid)
        else $error("accepted transaction produced no result on time");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_result.overflow && o_result.div_by_zero))
        else $error("overflow and div_by_zero set together");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.div_by_zero) |->
            (o_result.res_real == '0 && o_result.res_imag == '0))
        else $error("divide by zero result is not zero");

    a_no_result_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result transaction right after reset");

endmodule

bind complex_number_alu_core cna_checker u_cna_checker (.*);

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// Complex number ALU testbench
// Drives a directed table of operand corners and then random transactions
// through the command port under several idle patterns. Every accepted
// transaction gets a predicted result, and each result strobe is compared
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import cna_pkg::*;

    localparam int WIDE      = 160;
    localparam int LATENCY   = 39;
    localparam int MAX_CYC   = 200000;
    localparam int N_RAND    = 1850;

    typedef struct {
        t_in_item  item;
        bit        known;
        t_out_item res;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      o_valid;
    t_out_item o_result;

    t_out_item pending_q[$];
    int        errors = 0;
    int        cycles = 0;
    t_row      rows[$];

    complex_number_alu_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYC) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [DATA_WIDTH-1:0] clamp(input logic signed [WIDE-1:0] v,
                                                    inout logic ovf);
        logic signed [WIDE-1:0] hi;
        logic signed [WIDE-1:0] lo;
        hi = (WIDE'(1) <<< (DATA_WIDTH - 1)) - 1;
        lo = -(WIDE'(1) <<< (DATA_WIDTH - 1));
        if (v > hi) begin
            ovf = 1'b1;
            return hi[DATA_WIDTH-1:0];
        end else if (v < lo) begin
            ovf = 1'b1;
            return lo[DATA_WIDTH-1:0];
        end
        return v[DATA_WIDTH-1:0];
    endfunction

    function automatic t_out_item complex_result(input t_in_item it);
        logic signed [WIDE-1:0] ar, ai, br, bi, re, im, den, nr, ni;
        t_out_item r;
        ar = it.a_real;
        ai = it.a_imag;
        br = it.b_real;
        bi = it.b_imag;
        r = '0;
        case (t_mode'(it.mode))
            MODE_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            MODE_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            MODE_MUL: begin
                re = (ar * br - ai * bi) >>> FRAC_BITS;
                im = (ar * bi + br * ai) >>> FRAC_BITS;
            end
            default: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    re = 0;
                    im = 0;
                    r.div_by_zero = 1'b1;
                end else begin
                    nr = (ar * br + ai * bi) <<< FRAC_BITS;
                    ni = (br * ai - ar * bi) <<< FRAC_BITS;
                    re = nr / den;
                    im = ni / den;
                end
            end
        endcase
        r.res_real = clamp(re, r.overflow);
        r.res_imag = clamp(im, r.overflow);
        return r;
    endfunction

    function automatic t_in_item make_item(input t_mode m, input logic [31:0] ar,
                                           input logic [31:0] ai, input logic [31:0] br,
                                           input logic [31:0] bi);
        t_in_item it;
        it.mode = m;
        it.a_real = ar;
        it.a_imag = ai;
        it.b_real = br;
        it.b_imag = bi;
        return it;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2: return 32'($urandom_range(32'h3ffff)) - 32'h20000;
            3: return 32'($urandom_range(32'h3ffffff)) - 32'h2000000;
            4: begin
                case ($urandom_range(4))
                    0: return 32'h7fffffff;
                    1: return 32'h80000000;
                    2: return 32'hffffffff;
                    3: return 32'h00000001;
                    default: return 32'h00010000;
                endcase
            end
            default: return '0;
        endcase
    endfunction

    task automatic send(input t_in_item it, input bit known, input t_out_item res,
                        input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        pending_q.push_back(known ? res : complex_result(it));
    endtask

    task automatic report(input string name, input logic [31:0] exp_v,
                          input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_valid) begin
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, o_result);
            end else begin
                exp_r = pending_q.pop_front();
                report("res_real", exp_r.res_real, o_result.res_real);
                report("res_imag", exp_r.res_imag, o_result.res_imag);
                report("overflow", 32'(exp_r.overflow), 32'(o_result.overflow));
                report("div_by_zero", 32'(exp_r.div_by_zero), 32'(o_result.div_by_zero));
            end
        end
    end

    initial begin
        t_in_item  it;
        t_out_item none;
        int        idle;
        none = '0;

        rows.push_back('{make_item(MODE_ADD, 0, 0, 0, 0), 1, '{0, 0, 0, 0}});
        rows.push_back('{make_item(MODE_ADD, 32'h7fffffff, 0, 32'h7fffffff, 0), 1,
                         '{32'h7fffffff, 0, 1, 0}});
        rows.push_back('{make_item(MODE_SUB, 32'h80000000, 0, 1, 0), 1,
                         '{32'h80000000, 0, 1, 0}});
        rows.push_back('{make_item(MODE_MUL, 32'h10000, 0, 32'h10000, 0), 1,
                         '{32'h10000, 0, 0, 0}});
        rows.push_back('{make_item(MODE_DIV, 32'h12345, 32'hfff00000, 0, 0), 1,
                         '{0, 0, 0, 1}});
        rows.push_back('{make_item(MODE_DIV, 0, 0, 0, 0), 1, '{0, 0, 0, 1}});
        rows.push_back('{make_item(MODE_DIV, 32'h7fffffff, 32'h80000000, 0, 0), 1,
                         '{0, 0, 0, 1}});
        rows.push_back('{make_item(MODE_SUB, 32'h7fffffff, 32'h80000000, 32'h80000000,
                                   32'h7fffffff), 0, none});
        rows.push_back('{make_item(MODE_MUL, 32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h80000000), 0, none});
        rows.push_back('{make_item(MODE_MUL, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                   32'h7fffffff), 0, none});
        rows.push_back('{make_item(MODE_MUL, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                                   32'h1), 0, none});
        rows.push_back('{make_item(MODE_MUL, 32'hfffe8000, 32'h18000, 32'h28000,
                                   32'hffff0000), 0, none});
        rows.push_back('{make_item(MODE_DIV, 32'h7fffffff, 32'h7fffffff, 1, 0), 0, none});
        rows.push_back('{make_item(MODE_DIV, 32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h80000000), 0, none});
        rows.push_back('{make_item(MODE_DIV, 32'h10000, 32'h10000, 32'h10000, 32'h10000),
                         0, none});
        rows.push_back('{make_item(MODE_DIV, 32'hfffeffff, 32'h3, 32'h7fffffff,
                                   32'hffffffff), 0, none});
        rows.push_back('{make_item(MODE_DIV, 32'h1, 32'hffffffff, 0, 32'h80000000), 0, none});
        rows.push_back('{make_item(MODE_ADD, 32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h80000000), 0, none});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) send(rows[k].item, rows[k].known, rows[k].res, 0);

        for (int n = 0; n < N_RAND; n++) begin
            case (n * 4 / N_RAND)
                0: idle = 0;
                1: idle = 53;
                2: idle = 26;
                default: idle = (n % 200 < 100) ? 0 : 53;
            endcase
            it.mode = 2'($urandom_range(3));
            it.a_real = rand_word();
            it.a_imag = rand_word();
            it.b_real = rand_word();
            it.b_imag = rand_word();
            if (t_mode'(it.mode) == MODE_DIV && $urandom_range(9) == 0) begin
                it.b_real = '0;
                it.b_imag = '0;
            end
            send(it, 0, none, idle);
        end
        start <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> complex_number_alu_core.f
hdl/cna_pkg.sv
hdl/cna_front.sv
hdl/cna_queue.sv
hdl/cna_back.sv
hdl/complex_number_alu_core.sv
hdl/cna_checker.sv
dv/tb_top.sv
